// ----- rtl/core/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 64;
    localparam int CMD_W       = 2;
    localparam int CAP_W       = 5;
    localparam int DEF_ENTRIES = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    // command codes
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd2;

    // one stored entry as it moves down the row
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // per-cell update control
    typedef struct packed {
        logic upd;       // state changes this cycle
        logic shift;     // take the neighbor's entry
        logic valid_nxt; // cell holds an entry after the update
    } t_cell_ctl;

endpackage

// ----- rtl/core/lkv_cell.sv -----
// One recency-ordered entry cell: key match and shift from its neighbor.
module lkv_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lkv_pkg::KEY_W-1:0]    i_key,
    input  lkv_pkg::t_cell_ctl           i_ctl,
    input  lkv_pkg::t_entry              i_prev,
    output logic                         o_match,
    output lkv_pkg::t_entry              o_entry
);
    import lkv_pkg::*;

    logic   r_valid;
    t_entry r_entry;

    // valid bit: control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.upd) begin
            r_valid <= i_ctl.valid_nxt;
        end
    end

    // payload moves one cell down, or the front entry lands in cell zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && i_ctl.shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_match = r_valid && (r_entry.key == i_key);
    assign o_entry = r_entry;

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key-value cache.
//
// Input channel (i_in_valid / o_in_ready) carries one item: i_cmd, i_lookup_key and
// i_write_value. Output channel (o_out_valid / i_out_ready) returns one result per
// item: o_hit and o_read_value. Configuration channel (i_cfg_valid / o_cfg_ready)
// writes the capacity; writes after the first item are dropped until reset.
// Entries sit in a row of cells ordered by recency, cell zero most recent.
// All cells compare the key in parallel and the row shifts in the same cycle,
// so the result is shown the cycle after acceptance, and one item per cycle is
// sustained while the receiver takes each result.
// The result sits in an output register; while it waits, a new item is still
// taken if the receiver takes the pending result in the same cycle, otherwise
// the input stalls.
// Reset clears all valid bits, the count and the output valid flag together;
// there is no clearing pass. Capacity returns to ten.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_capacity,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lkv_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [lkv_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  i_write_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic signed [lkv_pkg::VAL_W-1:0]  o_read_value
);
    import lkv_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0] r_cap;
    logic             r_started;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    logic             r_hit;
    logic [VAL_W-1:0] r_rval;

    logic [CW-1:0]    eff_cap;
    logic [WW-1:0]    cap_wide;
    logic             accept;
    logic             lookup;
    logic             hit;
    logic             full;
    logic             upd;
    logic [IW-1:0]    hit_idx;
    logic [IW-1:0]    limit;
    logic [VAL_W-1:0] hit_val;
    logic [ENTRIES-1:0] match;
    t_entry           front;
    t_entry           cell_q [ENTRIES];
    t_cell_ctl        ctl    [ENTRIES];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    // capacity register, frozen after the first item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_started <= 1'b0;
        end else begin
            if (i_cfg_valid && !r_started) begin
                r_cap <= i_cfg_capacity;
            end
            if (accept) begin
                r_started <= 1'b1;
            end
        end
    end

    // clamp capacity to 1..ENTRIES
    assign cap_wide = WW'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (cap_wide > WW'(ENTRIES)) begin
            eff_cap = CW'(ENTRIES);
        end else begin
            eff_cap = cap_wide[CW-1:0];
        end
    end

    // match reduction: keys are unique so at most one cell matches
    always_comb begin
        hit_idx = '0;
        hit_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                hit_idx = hit_idx | IW'(i);
                hit_val = hit_val | cell_q[i].value;
            end
        end
    end

    assign lookup = (i_cmd == CMD_GET) || (i_cmd == CMD_PUT) || (i_cmd == CMD_ACCESS);
    assign hit    = lookup && (|match);
    assign full   = (r_count >= eff_cap);
    assign upd    = accept && ((i_cmd == CMD_PUT) || (i_cmd == CMD_ACCESS) || hit);

    // last cell that shifts, and the entry that lands in cell zero
    always_comb begin
        front.key = i_lookup_key;
        if (hit) begin
            limit       = hit_idx;
            n_count     = r_count;
            front.value = (i_cmd == CMD_PUT) ? i_write_value : hit_val;
        end else begin
            limit       = full ? IW'(r_count - CW'(1)) : IW'(r_count);
            n_count     = full ? r_count : r_count + CW'(1);
            front.value = (i_cmd == CMD_PUT) ? i_write_value : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (upd) begin
            r_count <= n_count;
        end
    end

    // the cell row
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign ctl[g].upd       = upd;
        assign ctl[g].shift     = (IW'(g) <= limit);
        assign ctl[g].valid_nxt = (CW'(g) < n_count);

        lkv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (i_lookup_key),
            .i_ctl   (ctl[g]),
            .i_prev  ((g == 0) ? front : cell_q[(g == 0) ? 0 : g - 1]),
            .o_match (match[g]),
            .o_entry (cell_q[g])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit  <= hit;
            r_rval <= (hit && (i_cmd != CMD_PUT)) ? hit_val : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_read_value = r_rval;

endmodule

// ----- rtl/core/lkv_checker.sv -----
// Port-level assertions for the LRU key-value cache, bound to the top level.
module lkv_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_hit,
    input logic signed [lkv_pkg::VAL_W-1:0]  o_read_value
);
    import lkv_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value) && $stable(o_hit))
        else $error("result changed while stalled");

    // every accepted item shows a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item gave no result");

    // a miss never returns data
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_read_value == '0)
        else $error("miss with nonzero value");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
